// ----- hdl/bmg_pkg.sv -----
// shared constants and tables for the box-muller gaussian generator
// used by bmg_log2, bmg_cos and the top level; depends on nothing
package bmg_pkg;

    localparam int LOG_FRAC     = 30;
    localparam int LOG_LAT      = 36;
    localparam int COS_LAT      = 21;
    localparam int HORNER_STEPS = 6;

    localparam logic [27:0] LN2_Q28     = 28'd186065279;
    localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
    localparam logic [31:0] ONE_Q30     = 32'd1073741824;

    // taylor divisors, highest order term first
    function automatic logic [7:0] cos_div(input int k);
        logic [7:0] d;
        case (k)
            0:       d = 8'd132;
            1:       d = 8'd90;
            2:       d = 8'd56;
            3:       d = 8'd30;
            4:       d = 8'd12;
            default: d = 8'd2;
        endcase
        return d;
    endfunction

    // floor(2^33 / divisor)
    function automatic logic [32:0] cos_recip(input int k);
        logic [32:0] r;
        case (k)
            0:       r = 33'd65075262;
            1:       r = 33'd95443717;
            2:       r = 33'd153391689;
            3:       r = 33'd286331153;
            4:       r = 33'd715827882;
            default: r = 33'd4294967296;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/bmg_log2.sv -----
// radius path front half: t = -2 ln u in unsigned Q30 from the radius code
// log2 by one squaring per stage; depends on bmg_pkg
module bmg_log2 #(
    parameter int RADIUS_BITS = 32
) (
    input  logic                                        aclk,
    input  logic                                        en,
    input  logic [RADIUS_BITS-1:0]                      code,
    output logic [$clog2(RADIUS_BITS+1)+bmg_pkg::LOG_FRAC:0] t_q30
);
    localparam int MW = RADIUS_BITS + 1;
    localparam int EW = $clog2(RADIUS_BITS + 1);
    localparam int LW = EW + bmg_pkg::LOG_FRAC;
    localparam int HW = LW - 18;
    localparam int PW = LW + 28;
    localparam int NSQ = bmg_pkg::LOG_FRAC;

    logic [MW-1:0]    m_reg;
    logic [MW-1:0]    m2_reg;
    logic [EW-1:0]    e2_reg;
    logic [EW-1:0]    lead;
    logic [EW-1:0]    sh;
    logic [MW+30:0]   wide;
    logic [30:0]      x_reg [0:NSQ];
    logic [NSQ-1:0]   f_reg [0:NSQ];
    logic [EW-1:0]    e_reg [0:NSQ];
    logic [LW-1:0]    lval_reg;
    logic [17+28:0]   pp_lo_reg;
    logic [HW+27:0]   pp_hi_reg;
    logic [PW-1:0]    prod;

    always_comb begin
        lead = '0;
        for (int i = 0; i < MW; i++) begin
            if (m_reg[i]) begin
                lead = EW'(i);
            end
        end
    end

    assign sh   = EW'(MW - 1) - e2_reg;
    assign wide = {m2_reg, 31'b0} << sh;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg    <= {1'b0, code} + MW'(1);
            m2_reg   <= m_reg;
            e2_reg   <= lead;
            x_reg[0] <= wide[MW+30 -: 31];
            f_reg[0] <= '0;
            e_reg[0] <= e2_reg;
        end
    end

    for (genvar i = 1; i <= NSQ; i++) begin : g_sq
        logic [61:0] sq;
        logic [31:0] y;
        assign sq = 62'(x_reg[i-1]) * 62'(x_reg[i-1]);
        assign y  = sq[61:30];
        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i] <= y[31] ? y[31:1] : y[30:0];
                f_reg[i] <= {f_reg[i-1][NSQ-2:0], y[31]};
                e_reg[i] <= e_reg[i-1];
            end
        end
    end

    assign prod = (PW'(pp_hi_reg) << 18) + PW'(pp_lo_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            lval_reg  <= (LW'(RADIUS_BITS) << bmg_pkg::LOG_FRAC) - {e_reg[NSQ], f_reg[NSQ]};
            pp_lo_reg <= 46'(lval_reg[17:0]) * 46'(bmg_pkg::LN2_Q28);
            pp_hi_reg <= (HW+28)'(lval_reg[LW-1:18]) * (HW+28)'(bmg_pkg::LN2_Q28);
            t_q30     <= prod[PW-1:27];
        end
    end

endmodule

// ----- hdl/bmg_sqrt.sv -----
// pipelined integer square root, one root bit per stage
// no dependencies
module bmg_sqrt #(
    parameter int IN_W = 58
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [IN_W-1:0]   radicand,
    output logic [IN_W/2-1:0] root
);
    localparam int RW = IN_W / 2;

    logic [RW:0]     rem_reg  [0:RW-1];
    logic [RW-1:0]   root_reg [0:RW-1];
    logic [IN_W-1:0] v_reg    [0:RW-1];

    for (genvar i = 0; i < RW; i++) begin : g_stage
        logic [RW:0]     rem_in;
        logic [RW-1:0]   root_in;
        logic [IN_W-1:0] v_in;
        logic [RW+2:0]   rem_sh;
        logic [RW+2:0]   trial;
        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign v_in    = radicand;
        end else begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign v_in    = v_reg[i-1];
        end
        assign rem_sh = {rem_in, v_in[IN_W-1:IN_W-2]};
        assign trial  = (RW+3)'({root_in, 2'b01});
        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[i] <= v_in << 2;
                if (rem_sh >= trial) begin
                    rem_reg[i]  <= (RW+1)'(rem_sh - trial);
                    root_reg[i] <= {root_in[RW-2:0], 1'b1};
                end else begin
                    rem_reg[i]  <= rem_sh[RW:0];
                    root_reg[i] <= {root_in[RW-2:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

// ----- hdl/bmg_cos.sv -----
// cosine of the angle fraction: quadrant fold plus taylor horner steps in Q30
// three stages per horner step; depends on bmg_pkg
module bmg_cos #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output logic [30:0]           cos_mag,
    output logic                  cos_neg
);
    localparam int NH = bmg_pkg::HORNER_STEPS;

    logic [31:0]        turn;
    logic [30:0]        fold;
    logic [61:0]        th_prod;
    logic [30:0]        theta_reg;
    logic               neg1_reg;
    logic [61:0]        t2_prod;
    logic [31:0]        t2_reg  [0:NH];
    logic signed [31:0] c_reg   [0:NH];
    logic               neg_reg [0:NH];

    assign turn    = 32'(angle) << (32 - ANGLE_BITS);
    assign fold    = turn[30] ? (bmg_pkg::ONE_Q30[30:0] - {1'b0, turn[29:0]})
                              : {1'b0, turn[29:0]};
    assign th_prod = 62'(fold) * 62'(bmg_pkg::PI_HALF_Q30);
    assign t2_prod = 62'(theta_reg) * 62'(theta_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            theta_reg  <= th_prod[60:30];
            neg1_reg   <= turn[31] ^ turn[30];
            t2_reg[0]  <= t2_prod[61:30];
            c_reg[0]   <= signed'(bmg_pkg::ONE_Q30);
            neg_reg[0] <= neg1_reg;
        end
    end

    for (genvar k = 0; k < NH; k++) begin : g_horner
        localparam logic [7:0]  DIV   = bmg_pkg::cos_div(k);
        localparam logic [32:0] RECIP = bmg_pkg::cos_recip(k);
        logic [31:0] cabs;
        logic [62:0] p;
        logic [32:0] a_reg;
        logic        sa_reg;
        logic [31:0] t2a_reg;
        logic        na_reg;
        logic [65:0] qp;
        logic [32:0] a2_reg;
        logic [32:0] qe_reg;
        logic        sb_reg;
        logic [31:0] t2b_reg;
        logic        nb_reg;
        logic [40:0] r;
        logic [32:0] q;
        logic [33:0] c_next;

        assign cabs = c_reg[k][31] ? 32'(-c_reg[k]) : 32'(c_reg[k]);
        assign p    = 63'(t2_reg[k]) * 63'(cabs[30:0]);
        assign qp   = 66'(a_reg) * 66'(RECIP);
        // estimate is low by at most one
        assign r    = 41'(a2_reg) - 41'(qe_reg) * 41'(DIV);
        assign q    = (r >= 41'(DIV)) ? qe_reg + 33'd1 : qe_reg;
        assign c_next = sb_reg ? 34'(bmg_pkg::ONE_Q30) + 34'(q)
                               : 34'(bmg_pkg::ONE_Q30) - 34'(q);

        always_ff @(posedge aclk) begin
            if (en) begin
                a_reg        <= p[62:30];
                sa_reg       <= c_reg[k][31];
                t2a_reg      <= t2_reg[k];
                na_reg       <= neg_reg[k];
                a2_reg       <= a_reg;
                qe_reg       <= qp[65:33];
                sb_reg       <= sa_reg;
                t2b_reg      <= t2a_reg;
                nb_reg       <= na_reg;
                c_reg[k+1]   <= signed'(c_next[31:0]);
                t2_reg[k+1]  <= t2b_reg;
                neg_reg[k+1] <= nb_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_neg <= neg_reg[NH] ^ c_reg[NH][31];
            cos_mag <= c_reg[NH][31] ? 31'(-c_reg[NH]) : 31'(c_reg[NH]);
        end
    end

endmodule

// ----- hdl/box_muller_gaussian.sv -----
// top level of the box-muller gaussian generator: handshake, valid pipeline, output stage
// depends on bmg_pkg, bmg_log2, bmg_sqrt, bmg_cos
//
// One gaussian sample per input item, one item accepted every clock while the output is
// not held. The radius path (36 stages of log2, one stage per root bit of the square
// root, 2 output stages) sets the depth of the pipeline. The cosine path runs alongside
// and is delayed to meet it. A result that waits with m_axis_tready low holds the whole
// pipeline and the input; nothing is dropped or repeated. No state beyond the pipeline.
module box_muller_gaussian #(
    parameter int RADIUS_BITS = 32,
    parameter int ANGLE_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // uniform_radius [RADIUS_BITS-1:0], angle_fraction above it, zero padded
    input  logic [((RADIUS_BITS+ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // normal_sample [15:0]
    output logic [15:0] m_axis_tdata
);
    localparam int EW    = $clog2(RADIUS_BITS + 1);
    localparam int TW    = EW + bmg_pkg::LOG_FRAC + 1;
    localparam int VW    = TW + 20 + ((TW + 20) % 2);
    localparam int RW    = VW / 2;
    localparam int DLY   = bmg_pkg::LOG_LAT + RW - bmg_pkg::COS_LAT;
    localparam int TOTAL = bmg_pkg::LOG_LAT + RW + 2;
    localparam int PRW   = RW + 31;
    localparam int QW    = PRW + 1 - 44;

    logic              en;
    logic [TOTAL-1:0]  valid_reg;
    logic [TW-1:0]     t_q30;
    logic [RW-1:0]     radius;
    logic [30:0]       cos_mag;
    logic              cos_neg;
    logic [30:0]       mag_dly [0:DLY-1];
    logic              neg_dly [0:DLY-1];
    logic [PRW-1:0]    prod_reg;
    logic              negp_reg;
    logic [PRW:0]      rnd;
    logic [QW-1:0]     q11;
    logic [15:0]       sample;
    logic [15:0]       out_reg;

    assign en            = !valid_reg[TOTAL-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = valid_reg[TOTAL-1];
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[TOTAL-2:0], s_axis_tvalid};
        end
    end

    bmg_log2 #(.RADIUS_BITS(RADIUS_BITS)) u_log2 (
        .aclk  (aclk),
        .en    (en),
        .code  (s_axis_tdata[RADIUS_BITS-1:0]),
        .t_q30 (t_q30)
    );

    bmg_sqrt #(.IN_W(VW)) u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (VW'({t_q30, 20'b0})),
        .root     (radius)
    );

    bmg_cos #(.ANGLE_BITS(ANGLE_BITS)) u_cos (
        .aclk    (aclk),
        .en      (en),
        .angle   (s_axis_tdata[RADIUS_BITS+ANGLE_BITS-1:RADIUS_BITS]),
        .cos_mag (cos_mag),
        .cos_neg (cos_neg)
    );

    for (genvar i = 0; i < DLY; i++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (en) begin
                mag_dly[i] <= (i == 0) ? cos_mag : mag_dly[(i == 0) ? 0 : i-1];
                neg_dly[i] <= (i == 0) ? cos_neg : neg_dly[(i == 0) ? 0 : i-1];
            end
        end
    end

    // round half up on the magnitude, sign applied after
    assign rnd = {1'b0, prod_reg} + ((PRW+1)'(1) << 43);
    assign q11 = rnd[PRW:44];

    always_comb begin
        if (negp_reg) begin
            sample = (q11 > QW'(32768)) ? 16'h8000 : 16'(-q11);
        end else begin
            sample = (q11 > QW'(32767)) ? 16'h7fff : 16'(q11);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PRW'(radius) * PRW'(mag_dly[DLY-1]);
            negp_reg <= neg_dly[DLY-1];
            out_reg  <= sample;
        end
    end

    a_accept_enters : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> valid_reg[0])
        else $error("accepted item did not enter the pipeline");

    a_cos_range : assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[TOTAL-3] |-> (mag_dly[DLY-1] <= bmg_pkg::ONE_Q30[30:0]))
        else $error("cosine magnitude above one");

    a_reset_empty : assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_axis_tvalid)
        else $error("result valid straight after reset");

endmodule
